/* src/tghf_pkg.sv */
// Package for the timestamp-gated hold queue: sizes, codes and transaction types.
// No dependencies; imported by the controller, the top level and the testbench.
`default_nettype none

package tghf_pkg;

    // Queue sizing
    localparam int HOLD_DEPTH = 32;
    localparam int IDX_W      = $clog2(HOLD_DEPTH);
    localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

    // Field widths
    localparam int TIME_W      = 48;
    localparam int TAG_W       = 16;
    localparam int CAP_W       = 32;
    localparam int LIMIT_W     = 6;
    localparam int CNT32_W     = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    // Register defaults and substitutes for a zero setting
    localparam logic [CAP_W-1:0]   RESET_CAP      = 32'd3000000;
    localparam logic [LIMIT_W-1:0] RESET_LIMIT    = 6'd32;
    localparam logic [CAP_W-1:0]   DEFAULT_CAP_US = 32'd2000000;
    localparam int                 DEFAULT_LIMIT  = 512;
    localparam int                 LIM_EFF_W      = $clog2(DEFAULT_LIMIT + 1);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CAP   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIMIT = 2'd1;

    // Actions
    localparam logic [1:0] ACT_PUBLISH = 2'd0;
    localparam logic [1:0] ACT_ENQUEUE = 2'd1;
    localparam logic [1:0] ACT_DRAIN   = 2'd2;
    localparam logic [1:0] ACT_FLUSH   = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_RELEASE = 2'd0;
    localparam logic [1:0] KIND_STATUS  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;
    localparam logic [1:0] KIND_ACK     = 2'd3;

    // Enqueue status codes
    localparam logic [1:0] ST_HELD      = 2'd0;
    localparam logic [1:0] ST_FULL_DROP = 2'd1;
    localparam logic [1:0] ST_WAIT      = 2'd2;
    localparam logic [1:0] ST_DIRECT    = 2'd3;

    typedef struct packed {
        logic [1:0]              action;
        logic signed [TIME_W-1:0] stamp_us;
        logic [TIME_W-1:0]       now_us;
        logic [TAG_W-1:0]        packet_tag;
        logic                    wait_when_full;
    } item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [TAG_W-1:0]   released_tag;
        logic               was_forced;
        logic [1:0]         enqueue_status;
        logic               mark_advanced;
        logic [TIME_W-1:0]  oldest_hold_us;
        logic [CNT32_W-1:0] forced_total;
        logic [CNT32_W-1:0] dropped_total;
        logic               last;
    } result_t;

    // One held entry as stored in the entry RAM
    typedef struct packed {
        logic signed [TIME_W-1:0] stamp;
        logic [TIME_W-1:0]        arrival;
        logic [TAG_W-1:0]         handle;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Effective configuration handed to the controller
    typedef struct packed {
        logic [CAP_W-1:0]     cap;
        logic [LIM_EFF_W-1:0] limit;
    } cfg_t;

    // Controller status seen by the top level
    typedef struct packed {
        logic [CNT_W-1:0] held;
        logic             closed;
        logic             idle;
    } status_t;

endpackage

`default_nettype wire

/* src/tghf_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module tghf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* src/tghf_ctrl.sv */
// Hold queue controller: action decode, drain scan pipeline, release/compaction pass.
// Depends on tghf_pkg and tghf_ram (entry store).
`default_nettype none

module tghf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire tghf_pkg::item_t  item,
    input  wire tghf_pkg::cfg_t   cfg,
    input  wire logic             slot_free,
    output logic                  emit_valid,
    output tghf_pkg::result_t     emit_data,
    output tghf_pkg::status_t     status
);

    import tghf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_PREP,
        S_SCAN,
        S_PASS_RD,
        S_PASS_DAT,
        S_SUMMARY
    } state_t;

    state_t state_reg, state_next;

    // Architectural state
    logic [CNT_W-1:0]         held_reg, held_next;
    logic signed [TIME_W-1:0] mark_stamp_reg, mark_stamp_next;
    logic                     mark_valid_reg, mark_valid_next;
    logic [TIME_W-1:0]        mark_time_reg, mark_time_next;
    logic                     closed_reg, closed_next;
    logic [CNT32_W-1:0]       forced_reg, forced_next;
    logic [CNT32_W-1:0]       dropped_reg, dropped_next;

    // Per-operation control
    logic                     flush_reg, flush_next;
    logic                     stalled_reg, stalled_next;
    logic [CNT_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     v1_reg, v1_next;
    logic                     v2_reg, v2_next;
    logic [IDX_W-1:0]         p_idx_reg, p_idx_next;
    logic [CNT_W-1:0]         w_idx_reg, w_idx_next;
    logic [HOLD_DEPTH-1:0]    rel_reg, rel_next;
    logic [HOLD_DEPTH-1:0]    frc_reg, frc_next;

    // Payload
    logic [TIME_W-1:0]        now_reg, now_next;
    result_t                  pend_reg, pend_next;
    logic [IDX_W-1:0]         i1_reg, i1_next;
    logic [IDX_W-1:0]         i2_reg, i2_next;
    logic signed [TIME_W:0]   age_reg, age_next;
    logic                     reached_reg, reached_next;
    logic [TIME_W-1:0]        oldest_reg, oldest_next;

    // Entry RAM port
    logic                     ram_wr_en;
    logic [IDX_W-1:0]         ram_wr_addr;
    entry_t                   ram_wr_data;
    logic                     ram_rd_en;
    logic [IDX_W-1:0]         ram_rd_addr;
    logic [ENTRY_W-1:0]       ram_rd_raw;
    entry_t                   rd_entry;

    logic                     accept;
    logic                     full;
    logic                     advance;
    logic signed [TIME_W:0]   cap_s;
    logic                     s3_aged;
    logic                     s3_rel;
    logic                     s3_frc;
    logic                     s3_older;
    logic                     scan_last;
    logic                     pass_last;
    logic                     scan_rd;

    tghf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HOLD_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    assign rd_entry = entry_t'(ram_rd_raw);

    assign accept  = item_valid && (state_reg == S_IDLE);
    assign full    = (LIM_EFF_W'(held_reg) >= cfg.limit)
                  || (held_reg >= CNT_W'(HOLD_DEPTH));
    assign advance = !mark_valid_reg || (item.stamp_us > mark_stamp_reg);

    // Scan stage 3: release decision and oldest-age tracking
    assign cap_s     = $signed({{(TIME_W + 1 - CAP_W){1'b0}}, cfg.cap});
    assign s3_aged   = stalled_reg && (age_reg > cap_s);
    assign s3_rel    = reached_reg || s3_aged;
    assign s3_frc    = s3_aged && !reached_reg;
    assign s3_older  = age_reg > $signed({1'b0, oldest_reg});
    assign scan_last = (CNT_W'(i2_reg) == (held_reg - CNT_W'(1)));
    assign pass_last = (CNT_W'(p_idx_reg) == (held_reg - CNT_W'(1)));
    assign scan_rd   = (state_reg == S_SCAN) && (rd_idx_reg < held_reg);

    assign status.held   = held_reg;
    assign status.closed = closed_reg;
    assign status.idle   = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        held_next       = held_reg;
        mark_stamp_next = mark_stamp_reg;
        mark_valid_next = mark_valid_reg;
        mark_time_next  = mark_time_reg;
        closed_next     = closed_reg;
        forced_next     = forced_reg;
        dropped_next    = dropped_reg;
        flush_next      = flush_reg;
        stalled_next    = stalled_reg;
        rd_idx_next     = rd_idx_reg;
        v1_next         = scan_rd;
        v2_next         = v1_reg;
        p_idx_next      = p_idx_reg;
        w_idx_next      = w_idx_reg;
        rel_next        = rel_reg;
        frc_next        = frc_reg;
        now_next        = now_reg;
        pend_next       = pend_reg;
        i1_next         = rd_idx_reg[IDX_W-1:0];
        i2_next         = i1_reg;
        age_next        = $signed({1'b0, now_reg}) - $signed({1'b0, rd_entry.arrival});
        reached_next    = mark_valid_reg && (rd_entry.stamp <= mark_stamp_reg);
        oldest_next     = oldest_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = held_reg[IDX_W-1:0];
        ram_wr_data = '0;
        ram_rd_en   = scan_rd;
        ram_rd_addr = rd_idx_reg[IDX_W-1:0];

        emit_valid               = 1'b0;
        emit_data                = '0;
        emit_data.forced_total   = forced_reg;
        emit_data.dropped_total  = dropped_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next = '0;
                    now_next  = item.now_us;
                    unique case (item.action)
                        ACT_PUBLISH:
                        begin
                            pend_next.result_kind   = KIND_ACK;
                            pend_next.mark_advanced = advance;
                            if (advance)
                            begin
                                mark_stamp_next = item.stamp_us;
                                mark_valid_next = 1'b1;
                                mark_time_next  = item.now_us;
                            end
                            state_next = S_ONE;
                        end
                        ACT_ENQUEUE:
                        begin
                            pend_next.result_kind = KIND_STATUS;
                            if (closed_reg)
                            begin
                                pend_next.enqueue_status = ST_DIRECT;
                                pend_next.released_tag   = item.packet_tag;
                            end
                            else if (full)
                            begin
                                if (item.wait_when_full)
                                begin
                                    pend_next.enqueue_status = ST_WAIT;
                                end
                                else
                                begin
                                    pend_next.enqueue_status = ST_FULL_DROP;
                                    dropped_next             = dropped_reg + CNT32_W'(1);
                                end
                            end
                            else
                            begin
                                pend_next.enqueue_status = ST_HELD;
                                ram_wr_en                = 1'b1;
                                ram_wr_data.stamp        = item.stamp_us;
                                ram_wr_data.arrival      = item.now_us;
                                ram_wr_data.handle       = item.packet_tag;
                                held_next                = held_reg + CNT_W'(1);
                            end
                            state_next = S_ONE;
                        end
                        ACT_DRAIN:
                        begin
                            flush_next  = 1'b0;
                            oldest_next = '0;
                            w_idx_next  = '0;
                            state_next  = (held_reg == '0) ? S_SUMMARY : S_PREP;
                        end
                        ACT_FLUSH:
                        begin
                            flush_next = 1'b1;
                            rel_next   = '1;
                            frc_next   = '0;
                            p_idx_next = '0;
                            w_idx_next = '0;
                            state_next = (held_reg == '0) ? S_SUMMARY : S_PASS_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ONE:
            begin
                emit_valid                = 1'b1;
                emit_data.result_kind     = pend_reg.result_kind;
                emit_data.released_tag    = pend_reg.released_tag;
                emit_data.enqueue_status  = pend_reg.enqueue_status;
                emit_data.mark_advanced   = pend_reg.mark_advanced;
                emit_data.last            = 1'b1;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end

            S_PREP:
            begin
                stalled_next = ($signed({1'b0, now_reg}) - $signed({1'b0, mark_time_reg}))
                               > cap_s;
                rd_idx_next  = '0;
                rel_next     = '0;
                frc_next     = '0;
                p_idx_next   = '0;
                state_next   = S_SCAN;
            end

            S_SCAN:
            begin
                if (scan_rd)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (v2_reg)
                begin
                    rel_next[i2_reg] = s3_rel;
                    frc_next[i2_reg] = s3_frc;
                    if (s3_frc)
                    begin
                        forced_next = forced_reg + CNT32_W'(1);
                    end
                    if (!s3_rel && s3_older)
                    begin
                        oldest_next = age_reg[TIME_W-1:0];
                    end
                    if (scan_last)
                    begin
                        state_next = S_PASS_RD;
                    end
                end
            end

            S_PASS_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = p_idx_reg;
                state_next  = S_PASS_DAT;
            end

            S_PASS_DAT:
            begin
                if (rel_reg[p_idx_reg])
                begin
                    emit_valid             = 1'b1;
                    emit_data.result_kind  = KIND_RELEASE;
                    emit_data.released_tag = rd_entry.handle;
                    emit_data.was_forced   = frc_reg[p_idx_reg];
                end
                else
                begin
                    // Survivor moves down to the next free slot
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = w_idx_reg[IDX_W-1:0];
                    ram_wr_data = rd_entry;
                    w_idx_next  = w_idx_reg + CNT_W'(1);
                end
                if (!rel_reg[p_idx_reg] || slot_free)
                begin
                    if (pass_last)
                    begin
                        state_next = S_SUMMARY;
                    end
                    else
                    begin
                        p_idx_next = p_idx_reg + IDX_W'(1);
                        state_next = S_PASS_RD;
                    end
                end
            end

            S_SUMMARY:
            begin
                emit_valid               = 1'b1;
                emit_data.result_kind    = KIND_SUMMARY;
                emit_data.oldest_hold_us = flush_reg ? '0 : oldest_reg;
                emit_data.last           = 1'b1;
                if (slot_free)
                begin
                    held_next   = flush_reg ? '0 : w_idx_reg;
                    closed_next = closed_reg || flush_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_reg       <= '0;
            mark_stamp_reg <= '0;
            mark_valid_reg <= 1'b0;
            mark_time_reg  <= '0;
            closed_reg     <= 1'b0;
            forced_reg     <= '0;
            dropped_reg    <= '0;
            flush_reg      <= 1'b0;
            stalled_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            p_idx_reg      <= '0;
            w_idx_reg      <= '0;
            rel_reg        <= '0;
            frc_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            mark_stamp_reg <= mark_stamp_next;
            mark_valid_reg <= mark_valid_next;
            mark_time_reg  <= mark_time_next;
            closed_reg     <= closed_next;
            forced_reg     <= forced_next;
            dropped_reg    <= dropped_next;
            flush_reg      <= flush_next;
            stalled_reg    <= stalled_next;
            rd_idx_reg     <= rd_idx_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            p_idx_reg      <= p_idx_next;
            w_idx_reg      <= w_idx_next;
            rel_reg        <= rel_next;
            frc_reg        <= frc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        pend_reg    <= pend_next;
        i1_reg      <= i1_next;
        i2_reg      <= i2_next;
        age_reg     <= age_next;
        reached_reg <= reached_next;
        oldest_reg  <= oldest_next;
    end

endmodule

`default_nettype wire

/* src/timestamp_gated_hold_fifo_top.sv */
// Top level of the timestamp-gated hold queue: configuration registers, result register.
// Depends on tghf_pkg and tghf_ctrl (which holds the entry RAM).
`default_nettype none

// Hold queue for side-stream packets gated by a video timestamp high-water mark.
// One transaction on the item channel is one action (publish, enqueue, drain or
// flush); it yields one or more result transactions, the final one flagged by
// last. The block handles one item at a time and holds item_stall high until
// the final result of that item has been loaded into the result register, so
// the next item may enter while that result still waits downstream.
// Drain: a pipelined scan reads every entry once to decide releases and count
// forced ones, then a second pass reads each entry again to emit releases and
// compact the survivors. Flush runs the release pass only, and an empty queue
// skips both passes. Both go through the single read port of the entry RAM.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while the block is idle. A cap of zero acts as 2 s and a
// queue limit of zero leaves only the RAM depth as the bound.
module timestamp_gated_hold_fifo_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire tghf_pkg::item_t                    item,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output tghf_pkg::result_t                       result,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tghf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [tghf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import tghf_pkg::*;

    // Configuration registers
    logic [CAP_W-1:0]   cap_reg;
    logic [LIMIT_W-1:0] limit_reg;
    cfg_t               cfg_eff;

    // Result register: parts the controller from downstream back-pressure
    logic    result_valid_reg;
    result_t result_reg;
    logic    slot_free;

    logic    emit_valid;
    result_t emit_data;
    status_t ctrl_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= RESET_CAP;
            limit_reg <= RESET_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CAP:   cap_reg   <= cfg_data[CAP_W-1:0];
                CFG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                default:   ;   // unknown index: ignored
            endcase
        end
    end

    // Zero settings fall back to their defaults
    assign cfg_eff.cap   = (cap_reg == '0) ? DEFAULT_CAP_US : cap_reg;
    assign cfg_eff.limit = (limit_reg == '0) ? LIM_EFF_W'(DEFAULT_LIMIT)
                                             : LIM_EFF_W'(limit_reg);

    tghf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cfg        (cfg_eff),
        .slot_free  (slot_free),
        .emit_valid (emit_valid),
        .emit_data  (emit_data),
        .status     (ctrl_status)
    );

    // Busy for the whole of an item, from accept to loading its last result
    assign item_stall = !ctrl_status.idle;

    assign slot_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit_valid && slot_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && slot_free)
        begin
            result_reg <= emit_data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // An accepted item always keeps the controller busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item accepted but controller not busy");

    // Once flushed, the queue never reopens
    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_status.closed |=> ctrl_status.closed)
        else $error("queue reopened without reset");

    // A held packet can only be reported while the queue is still open
    a_held_open: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.result_kind == KIND_STATUS)
        && (result.enqueue_status == ST_HELD) |-> !ctrl_status.closed)
        else $error("packet held in a closed queue");

    // Single-result actions always close their transaction sequence
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result.result_kind == KIND_ACK)
        || (result.result_kind == KIND_STATUS)) |-> result.last)
        else $error("publish or enqueue result without last");

    // Held count stays within the entry RAM
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_status.idle || (ctrl_status.held <= CNT_W'(HOLD_DEPTH)))
        else $error("held count beyond RAM depth");

endmodule

`default_nettype wire

/* tb/timestamp_gated_hold_fifo_top_tb.sv */
// Self-checking testbench for timestamp_gated_hold_fifo_top: directed and stream-shaped
// random actions are checked against an in-bench prediction of the hold queue.
// Needs tghf_pkg and the RTL.
module timestamp_gated_hold_fifo_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tghf_pkg::*;

    // Indexes beyond the two real registers: writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam longint STAMP_MIN       = -64'sd140737488355328;
    localparam longint STAMP_MAX       = 64'sd140737488355327;
    localparam longint TIME_MAX        = 64'd281474976710655;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     MAX_REPORTS     = 10;

    // Prediction of the hold queue plus the store of results still owed by the block.
    class hold_queue_model;
        longint                 slot_stamp[HOLD_DEPTH];
        longint                 slot_arrival[HOLD_DEPTH];
        logic [TAG_W-1:0]       slot_tag[HOLD_DEPTH];
        int                     held;
        longint                 mark;
        bit                     mark_set;
        longint                 mark_time;
        bit                     closed;
        logic [CNT32_W-1:0]     forced_n;
        logic [CNT32_W-1:0]     dropped_n;
        logic [CAP_W-1:0]       cap_reg;
        logic [LIMIT_W-1:0]     limit_reg;
        result_t                owed_results[$];
        int                     mismatches;
        int                     results_seen;
        int                     items_seen;

        function new();
            held      = 0;
            mark      = 0;
            mark_set  = 1'b0;
            mark_time = 0;
            closed    = 1'b0;
            forced_n  = '0;
            dropped_n = '0;
            cap_reg   = RESET_CAP;
            limit_reg = RESET_LIMIT;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_CAP)
                cap_reg = data;
            else if (idx == CFG_LIMIT)
                limit_reg = data[LIMIT_W-1:0];
        endfunction

        // Totals are taken from the counters as they stand when the result is formed
        function result_t shape(logic [1:0] kind, logic [TAG_W-1:0] tag, bit forced,
                                logic [1:0] status, bit adv, longint oldest);
            result_t r;
            r                = '0;
            r.result_kind    = kind;
            r.released_tag   = tag;
            r.was_forced     = forced;
            r.enqueue_status = status;
            r.mark_advanced  = adv;
            r.oldest_hold_us = oldest[TIME_W-1:0];
            r.forced_total   = forced_n;
            r.dropped_total  = dropped_n;
            return r;
        endfunction

        function void accept_item(item_t it);
            result_t batch[$];
            result_t r;
            longint  cap_eff;
            longint  now_t;
            longint  stamp_t;
            longint  age;
            longint  oldest;
            int      lim_eff;
            int      kept;
            bit      adv;
            bit      stalled;
            bit      reached;
            bit      aged;
            items_seen++;
            cap_eff = (cap_reg != '0) ? longint'(cap_reg) : longint'(DEFAULT_CAP_US);
            lim_eff = (limit_reg != '0) ? int'(limit_reg) : DEFAULT_LIMIT;
            now_t   = longint'(it.now_us);
            stamp_t = longint'($signed(it.stamp_us));
            case (it.action)
                ACT_PUBLISH:
                begin
                    adv = !mark_set || stamp_t > mark;
                    if (adv)
                    begin
                        mark      = stamp_t;
                        mark_set  = 1'b1;
                        mark_time = now_t;
                    end
                    batch.push_back(shape(KIND_ACK, '0, 1'b0, '0, adv, 0));
                end
                ACT_ENQUEUE:
                begin
                    if (closed)
                        batch.push_back(shape(KIND_STATUS, it.packet_tag, 1'b0, ST_DIRECT,
                                              1'b0, 0));
                    else if (held >= lim_eff || held >= HOLD_DEPTH)
                    begin
                        if (it.wait_when_full)
                            batch.push_back(shape(KIND_STATUS, '0, 1'b0, ST_WAIT, 1'b0, 0));
                        else
                        begin
                            dropped_n++;
                            batch.push_back(shape(KIND_STATUS, '0, 1'b0, ST_FULL_DROP,
                                                  1'b0, 0));
                        end
                    end
                    else
                    begin
                        slot_stamp[held]   = stamp_t;
                        slot_arrival[held] = now_t;
                        slot_tag[held]     = it.packet_tag;
                        held++;
                        batch.push_back(shape(KIND_STATUS, '0, 1'b0, ST_HELD, 1'b0, 0));
                    end
                end
                ACT_DRAIN:
                begin
                    stalled = (now_t - mark_time) > cap_eff;
                    oldest  = 0;
                    kept    = 0;
                    for (int i = 0; i < held; i++)
                    begin
                        age     = now_t - slot_arrival[i];
                        reached = mark_set && slot_stamp[i] <= mark;
                        aged    = stalled && age > cap_eff;
                        if (reached || aged)
                        begin
                            if (aged && !reached)
                                forced_n++;
                            batch.push_back(shape(KIND_RELEASE, slot_tag[i], aged && !reached,
                                                  '0, 1'b0, 0));
                        end
                        else
                        begin
                            // negative ages (time running backwards) never win here
                            if (age > oldest)
                                oldest = age;
                            slot_stamp[kept]   = slot_stamp[i];
                            slot_arrival[kept] = slot_arrival[i];
                            slot_tag[kept]     = slot_tag[i];
                            kept++;
                        end
                    end
                    held = kept;
                    // every release of one drain carries the count after the whole scan
                    foreach (batch[i])
                    begin
                        r              = batch[i];
                        r.forced_total = forced_n;
                        batch[i]       = r;
                    end
                    batch.push_back(shape(KIND_SUMMARY, '0, 1'b0, '0, 1'b0, oldest));
                end
                default:
                begin
                    for (int i = 0; i < held; i++)
                        batch.push_back(shape(KIND_RELEASE, slot_tag[i], 1'b0, '0, 1'b0, 0));
                    held   = 0;
                    closed = 1'b1;
                    batch.push_back(shape(KIND_SUMMARY, '0, 1'b0, '0, 1'b0, 0));
                end
            endcase
            r      = batch.pop_back();
            r.last = 1'b1;
            batch.push_back(r);
            foreach (batch[i])
                owed_results.push_back(batch[i]);
        endfunction

        function void log_failure(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] %s", $time, what);
        endfunction

        function void compare_result(result_t got);
            result_t want;
            string   diffs;
            results_seen++;
            if (owed_results.size() == 0)
            begin
                log_failure($sformatf("result %h arrived with nothing expected", got));
                return;
            end
            want  = owed_results.pop_front();
            diffs = "";
            if (got.result_kind !== want.result_kind)
                diffs = {diffs, $sformatf(" result_kind %0d/%0d",
                                          want.result_kind, got.result_kind)};
            if (got.released_tag !== want.released_tag)
                diffs = {diffs, $sformatf(" released_tag %h/%h",
                                          want.released_tag, got.released_tag)};
            if (got.was_forced !== want.was_forced)
                diffs = {diffs, $sformatf(" was_forced %0d/%0d",
                                          want.was_forced, got.was_forced)};
            if (got.enqueue_status !== want.enqueue_status)
                diffs = {diffs, $sformatf(" enqueue_status %0d/%0d",
                                          want.enqueue_status, got.enqueue_status)};
            if (got.mark_advanced !== want.mark_advanced)
                diffs = {diffs, $sformatf(" mark_advanced %0d/%0d",
                                          want.mark_advanced, got.mark_advanced)};
            if (got.oldest_hold_us !== want.oldest_hold_us)
                diffs = {diffs, $sformatf(" oldest_hold_us %0d/%0d",
                                          want.oldest_hold_us, got.oldest_hold_us)};
            if (got.forced_total !== want.forced_total)
                diffs = {diffs, $sformatf(" forced_total %0d/%0d",
                                          want.forced_total, got.forced_total)};
            if (got.dropped_total !== want.dropped_total)
                diffs = {diffs, $sformatf(" dropped_total %0d/%0d",
                                          want.dropped_total, got.dropped_total)};
            if (got.last !== want.last)
                diffs = {diffs, $sformatf(" last %0d/%0d", want.last, got.last)};
            if (diffs != "")
                log_failure($sformatf("result %0d differs (expected/actual):%s",
                                      results_seen, diffs));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    item_t                  item;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hold_queue_model hold_model;

    // Idling odds in percent for each side, changed between phases
    int     send_idle_pct;
    int     recv_idle_pct;
    // Long receiver hold-off: requested by the stimulus, counted down by the receiver
    bit     hold_request;
    int     hold_left;
    // Running video stamp and wall clock of the random stream
    longint vid_stamp;
    longint clock_us;
    int     tick_max;

    timestamp_gated_hold_fifo_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic item_t pack_item(logic [1:0] act, longint st, longint now,
                                        logic [TAG_W-1:0] tag, logic wt);
        item_t it;
        it                = '0;
        it.action         = act;
        it.stamp_us       = st[TIME_W-1:0];
        it.now_us         = now[TIME_W-1:0];
        it.packet_tag     = tag;
        it.wait_when_full = wt;
        return it;
    endfunction

    // One action of a plausible side stream: video stamps creep upwards, packet stamps sit
    // around and above them, the clock advances by up to tick_max. A few items are pure noise
    // (random stamps and times); publish is kept out of the noise so that a wild mark cannot
    // release everything for the rest of the run.
    function automatic item_t stream_item(int pub_pct, int enq_pct);
        item_t       it;
        logic [63:0] rnd;
        int          roll;
        longint      st;
        it  = '0;
        rnd = {$urandom, $urandom};
        if ($urandom_range(99, 0) < 4)
        begin
            it.action         = $urandom_range(1, 0) ? ACT_ENQUEUE : ACT_DRAIN;
            it.stamp_us       = rnd[TIME_W-1:0];
            it.packet_tag     = rnd[63:48];
            it.wait_when_full = rnd[48];
            rnd               = {$urandom, $urandom};
            it.now_us         = rnd[TIME_W-1:0];
            return it;
        end
        clock_us += longint'($urandom_range(tick_max, 0));
        roll      = $urandom_range(99, 0);
        st        = longint'(rnd[TIME_W-1:0]);
        if (roll < pub_pct)
        begin
            st = vid_stamp + longint'($urandom_range(400, 0)) - 100;
            if (st > vid_stamp)
                vid_stamp = st;
            it.action = ACT_PUBLISH;
        end
        else if (roll < pub_pct + enq_pct)
        begin
            st        = vid_stamp + longint'($urandom_range(600, 0)) - 100;
            it.action = ACT_ENQUEUE;
        end
        else
            it.action = ACT_DRAIN;
        it.stamp_us       = st[TIME_W-1:0];
        it.now_us         = clock_us[TIME_W-1:0];
        it.packet_tag     = rnd[63:48];
        it.wait_when_full = rnd[0];
        return it;
    endfunction

    // Offer one item; returns at the edge where it was taken, with valid still high so that
    // a following item can go straight on.
    task automatic send_item(input item_t it);
        if (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        hold_model.accept_item(it);
    endtask

    // One register write; the trailing edge keeps a lowered valid apart from the next raise
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        hold_model.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Stop offering and wait for every owed result, then idle before returning
    task automatic settle();
        item_valid <= 1'b0;
        while (hold_model.owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Receiver: checks each result transaction and decides the stall for the next cycle
    initial
    begin
        result_stall = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                hold_model.compare_result(result);
            if (hold_request)
            begin
                hold_left    = HOLD_OFF_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Watchdog: ends the run with an error if it has not finished by then
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results still owed", hold_model.owed_results.size());
        $display("[timestamp_gated_hold_fifo_top] ERROR");
        $finish;
    end

    initial
    begin
        logic [31:0] draw;
        hold_model    = new();
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        hold_request  = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 46;
        vid_stamp     = 2000;
        clock_us      = 3_000_000;
        tick_max      = 1000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unused indexes must leave both registers alone
        write_reg(CFG_SPARE_2, $urandom);
        write_reg(CFG_SPARE_3, $urandom);

        // Reset settings: empty drain with no mark, time running backwards, first mark at the
        // lowest stamp, an equal stamp that must not advance, then a release by stamp.
        send_item(pack_item(ACT_DRAIN, 0, 0, '0, 1'b0));
        send_item(pack_item(ACT_ENQUEUE, 5, 1000, 16'hFFFF, 1'b0));
        send_item(pack_item(ACT_ENQUEUE, STAMP_MIN, 500, 16'h0000, 1'b0));
        send_item(pack_item(ACT_DRAIN, 0, 400, '0, 1'b0));
        send_item(pack_item(ACT_PUBLISH, STAMP_MIN, 10, '0, 1'b0));
        send_item(pack_item(ACT_PUBLISH, STAMP_MIN, 20, '0, 1'b1));
        send_item(pack_item(ACT_DRAIN, 0, 2000, '0, 1'b0));

        // Smallest cap and limit: wait and drop on a full queue, forced release, the age
        // boundary (age equal to cap stays), then release by stamp at the latest time.
        settle();
        write_reg(CFG_CAP, 32'd1);
        write_reg(CFG_LIMIT, 32'd1);
        send_item(pack_item(ACT_ENQUEUE, STAMP_MAX, 2100, 16'h1234, 1'b1));
        send_item(pack_item(ACT_ENQUEUE, STAMP_MAX, 2100, 16'h4321, 1'b0));
        send_item(pack_item(ACT_DRAIN, STAMP_MAX, 3000, 16'hFFFF, 1'b1));
        send_item(pack_item(ACT_ENQUEUE, 7, 3000, 16'h5555, 1'b0));
        send_item(pack_item(ACT_DRAIN, 0, 3001, '0, 1'b0));
        send_item(pack_item(ACT_PUBLISH, 1000, 3002, '0, 1'b0));
        send_item(pack_item(ACT_DRAIN, 0, TIME_MAX, '0, 1'b0));

        // Zero settings fall back to a 2 s cap and the RAM depth; walk the stall edge
        settle();
        write_reg(CFG_CAP, '0);
        write_reg(CFG_LIMIT, '0);
        send_item(pack_item(ACT_ENQUEUE, STAMP_MAX, 4000, 16'hA5A5, 1'b0));
        send_item(pack_item(ACT_DRAIN, 0, 2_003_002, '0, 1'b0));
        send_item(pack_item(ACT_DRAIN, 0, 2_003_003, '0, 1'b0));
        send_item(pack_item(ACT_DRAIN, 0, 2_004_001, '0, 1'b0));

        // Random phase one: moderate cap, small limit, with stretches where video stalls.
        // Halfway through the sender stops until everything owed has come back.
        settle();
        write_reg(CFG_CAP, $urandom_range(5000, 500));
        write_reg(CFG_LIMIT, $urandom_range(8, 1));
        tick_max = int'(hold_model.cap_reg / 3);
        for (int n = 0; n < 60; n++)
        begin
            if (n == 30)
                settle();
            send_item(stream_item((n % 30) < 10 ? 0 : 25, 45));
        end

        // Random phase two: largest cap, a limit equal to the RAM depth, idling swapped. The
        // receiver holds off for a long stretch at the start of a burst of enqueues larger than
        // the queue depth; one publish then lets a single drain release the lot.
        settle();
        send_idle_pct = 46;
        recv_idle_pct = 16;
        write_reg(CFG_CAP, 32'hFFFF_FFFF);
        write_reg(CFG_LIMIT, 32'd32);
        tick_max     = 1000;
        hold_request = 1'b1;
        for (int n = 0; n < 36; n++)
        begin
            draw = $urandom;
            send_item(pack_item(ACT_ENQUEUE, vid_stamp + 1000 + n, clock_us + n,
                                draw[15:0], draw[16]));
        end
        vid_stamp += 5000;
        clock_us  += 100;
        send_item(pack_item(ACT_PUBLISH, vid_stamp, clock_us, '0, 1'b0));
        send_item(pack_item(ACT_DRAIN, 0, clock_us, '0, 1'b0));
        for (int n = 0; n < 28; n++)
            send_item(stream_item(10, 65));

        // Random phase three: tiny cap so stalls are frequent, limit zero, no idling
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_CAP, $urandom_range(200, 1));
        write_reg(CFG_LIMIT, '0);
        tick_max = int'(hold_model.cap_reg);
        for (int n = 0; n < 50; n++)
            send_item(stream_item(25, 45));

        // Close the queue with entries still held; afterwards enqueues pass straight
        // through and a second flush only reports.
        for (int n = 0; n < 3; n++)
        begin
            draw = $urandom;
            send_item(pack_item(ACT_ENQUEUE, vid_stamp + 10000 + n, clock_us, draw[15:0], 1'b0));
        end
        send_item(pack_item(ACT_FLUSH, 0, clock_us, '0, 1'b0));
        for (int n = 0; n < 10; n++)
            send_item(stream_item(25, 45));
        send_item(pack_item(ACT_FLUSH, 0, clock_us, '0, 1'b1));

        settle();
        repeat (20) @(posedge clk);

        $display("Covered %0d input and %0d result transactions (%0d forced, %0d dropped)",
                 hold_model.items_seen, hold_model.results_seen,
                 hold_model.forced_n, hold_model.dropped_n);
        $display("over reset, smallest, zero and largest settings, a full queue under hold-off and close");
        if (hold_model.mismatches == 0)
            $display("[timestamp_gated_hold_fifo_top] OK");
        else
            $display("[timestamp_gated_hold_fifo_top] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
src/tghf_pkg.sv
src/tghf_ram.sv
src/tghf_ctrl.sv
src/timestamp_gated_hold_fifo_top.sv
tb/timestamp_gated_hold_fifo_top_tb.sv
